### design/lpct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpct_pkg: shared definitions for the page cache translator
// Field widths, reset values, command and status codes, controller states
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lpct_pkg;

  localparam int unsigned DEFAULT_SLOT_COUNT = 8;
  localparam int unsigned PAGE_OFFSET_BITS   = 10;
  localparam int unsigned VIRT_ADDR_W        = 23;
  // The external memory spans exactly the virtual address space, so the page
  // number is simply the upper part of the address.
  localparam int unsigned PAGE_NUMBER_BITS   = VIRT_ADDR_W - PAGE_OFFSET_BITS;
  localparam int unsigned SLOT_W             = 3;
  localparam int unsigned ADDR_W             = 32;
  localparam int unsigned STATUS_W           = 3;

  localparam logic [ADDR_W-1:0] SRAM_BASE_RESET = 32'h2000_A000;

  typedef enum logic [0:0] {
    CMD_TRANSLATE  = 1'b0,
    CMD_MARK_DIRTY = 1'b1
  } command_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_HIT           = 3'd0,
    STS_LOAD_FREE     = 3'd1,
    STS_REPLACE_CLEAN = 3'd2,
    STS_WRITE_BACK    = 3'd3,
    STS_MARKED_DIRTY  = 3'd4,
    STS_NOT_CACHED    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_MATCH  = 2'd1,
    ST_COMMIT = 2'd2
  } state_e;

  typedef struct packed {
    logic capture;
    logic match_en;
    logic commit;
  } lpct_cmd_t;

  typedef struct packed {
    logic out_room;
  } lpct_stat_t;

endpackage

### design/lru_page_cache_translator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_cache_translator: fully associative page cache translator
// Translates virtual addresses to SRAM slot addresses with LRU replacement
// and dirty tracking, and marks cached pages dirty.
// ----------------------------------------------------------------------------
// After a transaction is accepted, the match state compares the page against
// all slot tags and encodes the lowest matching and lowest free slot, and
// the commit state updates the LRU stack and slot state and loads the result
// register. A new transaction is accepted in the commit state, so it overlaps
// the end of the one before; a stalled result register holds the commit
// state. All state resets at once; there is no clearing pass. Write the SRAM
// base register only while idle.
module lru_page_cache_translator import lpct_pkg::*; #(
  parameter int unsigned SLOT_COUNT = DEFAULT_SLOT_COUNT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ADDR_W-1:0]           cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        command_i,
  input  logic [VIRT_ADDR_W-1:0]      virt_addr_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [STATUS_W-1:0]         status_o,
  output logic [SLOT_W-1:0]           slot_o,
  output logic [ADDR_W-1:0]           sram_addr_o,
  output logic [PAGE_NUMBER_BITS-1:0] victim_page_o
);

  lpct_cmd_t  dp_cmd;
  lpct_stat_t dp_stat;

  lpct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  lpct_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .command_i     (command_i),
    .virt_addr_i   (virt_addr_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .sram_addr_o   (sram_addr_o),
    .victim_page_o (victim_page_o)
  );

`ifndef NO_ASSERTIONS
  // A commit must never overwrite a result that is still waiting.
  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.commit |-> (!out_valid_o || !out_stall_i))
    else $error("commit while result register is blocked");

  // Every captured transaction goes through the tag match next cycle.
  a_capture_then_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.capture |=> dp_cmd.match_en)
    else $error("captured transaction skipped the tag match");

  // Tag match and commit never overlap.
  a_match_not_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dp_cmd.match_en && dp_cmd.commit))
    else $error("tag match and commit in the same cycle");

  // A page that is not cached reports zero slot, address and victim.
  a_not_cached_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STS_NOT_CACHED)) |->
      ((slot_o == '0) && (sram_addr_o == '0) && (victim_page_o == '0)))
    else $error("not-cached result carries nonzero fields");
`endif

endmodule

### design/lpct_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpct_ctrl: sequencing controller
// Steps each transaction through tag match and commit, and accepts the next
// input transaction in the commit cycle when the result register has room.
// ----------------------------------------------------------------------------
module lpct_ctrl import lpct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  lpct_stat_t stat_i,
  output lpct_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd_o.match_en = 1'b1;
        state_d        = ST_COMMIT;
      end
      ST_COMMIT: begin
        // The state update and the next capture share one edge, so the next
        // tag match already sees the updated slots.
        if (stat_i.out_room) begin
          cmd_o.commit = 1'b1;
          in_stall_o   = 1'b0;
          if (in_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_MATCH;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### design/lpct_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpct_datapath: slot tags, LRU stack and result register
// Holds the slot pages, in-use and dirty bits, the LRU stack with its fill
// count, the match results and the output register of the translator.
// ----------------------------------------------------------------------------
module lpct_datapath import lpct_pkg::*; #(
  parameter int unsigned SLOT_COUNT = DEFAULT_SLOT_COUNT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lpct_cmd_t                   cmd_i,
  output lpct_stat_t                  stat_o,
  input  logic                        cfg_we_i,
  input  logic [ADDR_W-1:0]           cfg_wdata_i,
  input  logic                        command_i,
  input  logic [VIRT_ADDR_W-1:0]      virt_addr_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [STATUS_W-1:0]         status_o,
  output logic [SLOT_W-1:0]           slot_o,
  output logic [ADDR_W-1:0]           sram_addr_o,
  output logic [PAGE_NUMBER_BITS-1:0] victim_page_o
);

  localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned FW = $clog2(SLOT_COUNT + 1);
  localparam logic [SLOT_COUNT-1:0] ONE_VEC = SLOT_COUNT'(1);

  logic [ADDR_W-1:0]           sram_base_q;
  logic                        command_q;
  logic [VIRT_ADDR_W-1:0]      va_q;
  logic [PAGE_NUMBER_BITS-1:0] slot_page_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]       in_use_q;
  logic [SLOT_COUNT-1:0]       dirty_q;
  logic [SW-1:0]               lru_q [SLOT_COUNT];
  logic [SW-1:0]               lru_d [SLOT_COUNT];
  logic [FW-1:0]               fill_q, fill_d;

  logic                        hit_any_q, free_any_q;
  logic [SW-1:0]               hit_idx_q, free_idx_q;

  logic                        out_valid_q;
  status_e                     status_q;
  logic [SLOT_W-1:0]           slot_q;
  logic [ADDR_W-1:0]           sram_addr_q;
  logic [PAGE_NUMBER_BITS-1:0] victim_q;

  logic [PAGE_NUMBER_BITS-1:0] page_w;
  logic [PAGE_OFFSET_BITS-1:0] off_w;

  logic [SLOT_COUNT-1:0]       hit_vec, free_vec, hit_low, free_low;
  logic [SW-1:0]               hit_enc, free_enc;

  logic [SW-1:0]               victim_slot;
  logic [SW-1:0]               sel_slot;
  status_e                     sts;
  logic [PAGE_NUMBER_BITS-1:0] victim_page;
  logic [ADDR_W-1:0]           addr;
  logic                        mark, touch, load, set_dirty;

  logic [SLOT_COUNT-1:0]       found_vec, at_vec, low_mask;
  logic [SW-1:0]               lru_up [SLOT_COUNT];
  logic                        found, fill_full;

  assign page_w = va_q[VIRT_ADDR_W-1:PAGE_OFFSET_BITS];
  assign off_w  = va_q[PAGE_OFFSET_BITS-1:0];

  // Configuration register and captured transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sram_base_q <= SRAM_BASE_RESET;
    end else if (cfg_we_i) begin
      sram_base_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      command_q <= command_i;
      va_q      <= virt_addr_i;
    end
  end

  // Tag match: parallel compare, then the lowest set bit is isolated and
  // encoded, which picks the lowest matching slot and the lowest free slot.
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit_vec[i]  = in_use_q[i] && (slot_page_q[i] == page_w);
      free_vec[i] = !in_use_q[i];
    end
    hit_low  = hit_vec & (~hit_vec + ONE_VEC);
    free_low = free_vec & (~free_vec + ONE_VEC);
    hit_enc  = '0;
    free_enc = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (hit_low[i]) begin
        hit_enc = hit_enc | SW'(i);
      end
      if (free_low[i]) begin
        free_enc = free_enc | SW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.match_en) begin
      hit_any_q  <= |hit_vec;
      hit_idx_q  <= hit_enc;
      free_any_q <= |free_vec;
      free_idx_q <= free_enc;
    end
  end

  // Commit decision.
  always_comb begin
    victim_slot = lru_q[0];
    if ({1'b0, lru_q[0]} > (SW + 1)'(SLOT_COUNT - 1)) begin
      victim_slot = '0;
    end
    mark        = (command_q == CMD_MARK_DIRTY);
    sel_slot    = '0;
    sts         = STS_HIT;
    victim_page = '0;
    touch       = 1'b0;
    load        = 1'b0;
    set_dirty   = 1'b0;
    if (mark) begin
      if (hit_any_q) begin
        sel_slot  = hit_idx_q;
        sts       = STS_MARKED_DIRTY;
        set_dirty = 1'b1;
      end else begin
        sts = STS_NOT_CACHED;
      end
    end else if (hit_any_q) begin
      sel_slot = hit_idx_q;
      sts      = STS_HIT;
      touch    = 1'b1;
    end else if (free_any_q) begin
      sel_slot = free_idx_q;
      sts      = STS_LOAD_FREE;
      touch    = 1'b1;
      load     = 1'b1;
    end else begin
      sel_slot = victim_slot;
      touch    = 1'b1;
      load     = 1'b1;
      if (dirty_q[victim_slot]) begin
        sts         = STS_WRITE_BACK;
        victim_page = slot_page_q[victim_slot];
      end else begin
        sts = STS_REPLACE_CLEAN;
      end
    end
    if (mark && !hit_any_q) begin
      addr = '0;
    end else begin
      addr = sram_base_q + (ADDR_W'(sel_slot) << PAGE_OFFSET_BITS) + ADDR_W'(off_w);
    end
  end

  // LRU stack update: index 0 is the least recently used entry. A slot
  // already in the stack is pulled out and placed on top; a full stack
  // drops its bottom entry.
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      found_vec[i] = (FW'(i) < fill_q) && (lru_q[i] == sel_slot);
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      low_mask = '0;
      for (int j = 0; j < SLOT_COUNT; j++) begin
        if (j <= i) begin
          low_mask[j] = 1'b1;
        end
      end
      at_vec[i] = |(found_vec & low_mask);
    end
    found     = |found_vec;
    fill_full = (fill_q == FW'(SLOT_COUNT));
    for (int i = 0; i < SLOT_COUNT - 1; i++) begin
      lru_up[i] = lru_q[i + 1];
    end
    lru_up[SLOT_COUNT-1] = sel_slot;
    lru_d  = lru_q;
    fill_d = fill_q;
    if (found) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (at_vec[i]) begin
          lru_d[i] = (FW'(i + 1) == fill_q) ? sel_slot : lru_up[i];
        end
      end
    end else if (fill_full) begin
      lru_d = lru_up;
    end else begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (FW'(i) == fill_q) begin
          lru_d[i] = sel_slot;
        end
      end
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      dirty_q  <= '0;
      fill_q   <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        lru_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      if (touch) begin
        lru_q  <= lru_d;
        fill_q <= fill_d;
      end
      if (load) begin
        in_use_q[sel_slot] <= 1'b1;
        dirty_q[sel_slot]  <= 1'b0;
      end
      if (set_dirty) begin
        dirty_q[sel_slot] <= 1'b1;
      end
    end
  end

  // Slot pages are only read where the slot is in use, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && load) begin
      slot_page_q[sel_slot] <= page_w;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q    <= sts;
      slot_q      <= SLOT_W'(sel_slot);
      sram_addr_q <= addr;
      victim_q    <= victim_page;
    end
  end

  assign stat_o.out_room = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign slot_o          = slot_q;
  assign sram_addr_o     = sram_addr_q;
  assign victim_page_o   = victim_q;

endmodule
